[design/scc_pkg.sv]
// Shared constants and types for the sparse constraint checker.
package scc_pkg;

  localparam int VAR_DEPTH = 4096;
  localparam int VAR_AW    = $clog2(VAR_DEPTH);
  localparam int FRAC_BITS = 16;

  localparam int IDX_W   = 12;
  localparam int VAL_W   = 32;
  localparam int ROW_W   = 20;
  localparam int ACC_W   = 64;
  localparam int NVAR_W  = 13;
  localparam int SLACK_W = 31;
  localparam int CFG_W   = 31;
  localparam int CFG_IDX_W = 1;

  // Relative slack: |rhs| * REL_MUL >> REL_SHIFT approximates |rhs| / 1000.
  localparam int REL_MUL_W = 11;
  localparam logic [REL_MUL_W-1:0] REL_MUL = REL_MUL_W'(1049);
  localparam int REL_SHIFT = 20;
  localparam int REL_W     = VAL_W + REL_MUL_W;

  typedef logic [1:0] action_t;
  localparam action_t ACT_LOAD = 2'd0;
  localparam action_t ACT_TERM = 2'd1;
  localparam action_t ACT_END  = 2'd2;

  typedef logic [1:0] sense_t;
  localparam sense_t SENSE_LE  = 2'd0;
  localparam sense_t SENSE_GE  = 2'd1;
  localparam sense_t SENSE_EQ  = 2'd2;
  localparam sense_t SENSE_BAD = 2'd3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_NUM_VARS  = 1'b0;
  localparam cfg_idx_t CFG_ABS_SLACK = 1'b1;

  localparam logic [NVAR_W-1:0]  NUM_VARS_RST  = NVAR_W'(4096);
  localparam logic [SLACK_W-1:0] ABS_SLACK_RST = SLACK_W'(66);

endpackage

[design/scc_in_if.sv]
// Input item channel: valid/ready handshake with load, term and row-end payload.
interface scc_in_if;
  import scc_pkg::*;

  logic                    valid;
  logic                    ready;
  action_t                 action;
  logic [IDX_W-1:0]        index;
  logic signed [VAL_W-1:0] value;
  sense_t                  sense;
  logic signed [VAL_W-1:0] rhs;

  modport source (output valid, action, index, value, sense, rhs, input ready);
  modport sink   (input valid, action, index, value, sense, rhs, output ready);
endinterface

[design/scc_out_if.sv]
// Result item channel: valid/ready handshake with the per-row check result.
interface scc_out_if;
  import scc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ROW_W-1:0]        row_number;
  logic signed [ACC_W-1:0] activity;
  logic                    violated;
  logic                    bad_sense;
  logic                    bad_index;
  logic                    any_violated;

  modport source (output valid, row_number, activity, violated, bad_sense, bad_index,
                  any_violated, input ready);
  modport sink   (input valid, row_number, activity, violated, bad_sense, bad_index,
                  any_violated, output ready);
endinterface

[design/scc_ram.sv]
// Generic single-port RAM with registered read data.
module scc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/sparse_constraint_checker_unit.sv]
// Sparse constraint checker: variable store, multiply-accumulate and row check.
// A row-end item is checked in the accumulate stage and its result then registered for output.
// Throughput: one item per cycle unless stalled; the store is read at acceptance,
// then the multiply, the bound computation and the accumulate take one stage each.
// Only a row-end item blocked behind an untaken result stalls the pipeline.
// Synchronous active-low reset clears row state, flags and config, not the store.
module sparse_constraint_checker_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [scc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scc_pkg::CFG_W-1:0]        cfg_data,
  scc_in_if.sink                           in_if,
  scc_out_if.source                        out_if
);
  import scc_pkg::*;

  // configuration
  logic [NVAR_W-1:0]  num_vars_r;
  logic [SLACK_W-1:0] abs_slack_r;

  // pipeline control
  logic adv;
  logic accept;

  // stage 1: store read in flight
  logic                    s1_valid_r;
  action_t                 s1_action_r;
  logic                    s1_term_ok_r;
  logic signed [VAL_W-1:0] s1_value_r;
  sense_t                  s1_sense_r;
  logic signed [VAL_W-1:0] s1_rhs_r;

  // stage 2: products
  logic                    s2_valid_r;
  action_t                 s2_action_r;
  logic                    s2_term_ok_r;
  logic signed [ACC_W-1:0] s2_prod_r;
  sense_t                  s2_sense_r;
  logic signed [VAL_W-1:0] s2_rhs_r;
  logic [REL_W-1:0]        s2_rel_r;

  // stage 3: accumulate or check
  logic                    s3_valid_r;
  action_t                 s3_action_r;
  logic                    s3_term_ok_r;
  logic signed [ACC_W-1:0] s3_prod_r;
  sense_t                  s3_sense_r;
  logic signed [ACC_W-1:0] s3_hi_r;
  logic signed [ACC_W-1:0] s3_lo_r;

  // row state
  logic signed [ACC_W-1:0] acc_r;
  logic [ROW_W-1:0]        row_cnt_r;
  logic                    idx_err_r;
  logic                    sticky_r;

  // result register
  logic                    out_valid_r;
  logic [ROW_W-1:0]        out_row_r;
  logic signed [ACC_W-1:0] out_act_r;
  logic                    out_viol_r;
  logic                    out_bsense_r;
  logic                    out_bidx_r;
  logic                    out_any_r;

  // store
  logic [VAL_W-1:0] ram_rdata;
  logic             in_range;
  logic             ram_we;

  // combinational
  logic [VAL_W-1:0]        rhs_mag;
  logic signed [ACC_W-1:0] prod;
  logic [VAL_W:0]          slack;
  logic signed [ACC_W-1:0] r_scaled;
  logic signed [ACC_W-1:0] s_scaled;
  logic signed [ACC_W:0]   sum_ext;
  logic signed [ACC_W-1:0] acc_sat;
  logic                    viol;
  logic                    bsense;
  logic                    row_end;

  assign row_end = s3_valid_r && (s3_action_r == ACT_END);
  // stall only when a result must be written and the result register is held
  assign adv     = !(row_end && out_valid_r && !out_if.ready);
  assign in_if.ready = adv;
  assign accept  = in_if.valid && adv;

  assign in_range = (32'(in_if.index) < VAR_DEPTH);
  assign ram_we   = (in_if.action == ACT_LOAD) && in_range;

  scc_ram #(
    .WIDTH (VAL_W),
    .DEPTH (VAR_DEPTH)
  ) u_var_store (
    .clk   (clk),
    .en    (accept),
    .we    (ram_we),
    .addr  (VAR_AW'(in_if.index)),
    .wdata (in_if.value),
    .rdata (ram_rdata)
  );

  // stage 1 -> 2 math
  assign rhs_mag = s1_rhs_r[VAL_W-1] ? VAL_W'(-s1_rhs_r) : VAL_W'(s1_rhs_r);
  assign prod    = ACC_W'(s1_value_r) * ACC_W'($signed(ram_rdata));

  // stage 2 -> 3 math
  assign slack    = (VAL_W+1)'(s2_rel_r >> REL_SHIFT) + (VAL_W+1)'(abs_slack_r);
  assign r_scaled = ACC_W'(s2_rhs_r) <<< FRAC_BITS;
  assign s_scaled = ACC_W'(slack) <<< FRAC_BITS;

  // stage 3 math
  assign sum_ext = {acc_r[ACC_W-1], acc_r} + {s3_prod_r[ACC_W-1], s3_prod_r};
  always_comb begin
    if (sum_ext[ACC_W] != sum_ext[ACC_W-1]) begin
      acc_sat = sum_ext[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sat = sum_ext[ACC_W-1:0];
    end
  end

  always_comb begin
    viol   = 1'b0;
    bsense = 1'b0;
    case (s3_sense_r)
      SENSE_LE: viol = acc_r > s3_hi_r;
      SENSE_GE: viol = acc_r < s3_lo_r;
      SENSE_EQ: viol = (acc_r > s3_hi_r) || (acc_r < s3_lo_r);
      default:  bsense = 1'b1;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vars_r  <= NUM_VARS_RST;
      abs_slack_r <= ABS_SLACK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_VARS:  num_vars_r  <= cfg_data[NVAR_W-1:0];
        CFG_ABS_SLACK: abs_slack_r <= cfg_data[SLACK_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_action_r  <= in_if.action;
      s1_term_ok_r <= in_range && ({1'b0, in_if.index} < num_vars_r);
      s1_value_r   <= in_if.value;
      s1_sense_r   <= in_if.sense;
      s1_rhs_r     <= in_if.rhs;

      s2_action_r  <= s1_action_r;
      s2_term_ok_r <= s1_term_ok_r;
      s2_prod_r    <= prod;
      s2_sense_r   <= s1_sense_r;
      s2_rhs_r     <= s1_rhs_r;
      s2_rel_r     <= REL_W'(rhs_mag) * REL_W'(REL_MUL);

      s3_action_r  <= s2_action_r;
      s3_term_ok_r <= s2_term_ok_r;
      s3_prod_r    <= s2_prod_r;
      s3_sense_r   <= s2_sense_r;
      s3_hi_r      <= r_scaled + s_scaled;
      s3_lo_r      <= r_scaled - s_scaled;
    end
    if (adv && row_end) begin
      out_row_r    <= row_cnt_r;
      out_act_r    <= acc_r;
      out_viol_r   <= viol;
      out_bsense_r <= bsense;
      out_bidx_r   <= idx_err_r;
      out_any_r    <= sticky_r || viol || bsense || idx_err_r;
    end
  end

  // control and row state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      acc_r       <= '0;
      row_cnt_r   <= '0;
      idx_err_r   <= 1'b0;
      sticky_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid_r <= accept;
        s2_valid_r <= s1_valid_r;
        s3_valid_r <= s2_valid_r;
        if (s3_valid_r && (s3_action_r == ACT_TERM)) begin
          if (s3_term_ok_r) begin
            acc_r <= acc_sat;
          end else begin
            idx_err_r <= 1'b1;
          end
        end
        if (row_end) begin
          acc_r     <= '0;
          idx_err_r <= 1'b0;
          row_cnt_r <= row_cnt_r + ROW_W'(1);
          sticky_r  <= sticky_r || viol || bsense || idx_err_r;
        end
      end
      if (adv && row_end) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.row_number   = out_row_r;
  assign out_if.activity     = out_act_r;
  assign out_if.violated     = out_viol_r;
  assign out_if.bad_sense    = out_bsense_r;
  assign out_if.bad_index    = out_bidx_r;
  assign out_if.any_violated = out_any_r;

endmodule

[dv/tb_sparse_constraint_checker_unit.sv]
// Self-checking testbench for the sparse constraint checker: directed rows and random rows.
module tb_sparse_constraint_checker_unit;
  import scc_pkg::*;

  // Action code that the block ignores.
  localparam action_t ACT_NONE = 2'd3;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam int ITEMS_PER_PHASE = 100;

  typedef struct {
    logic [ROW_W-1:0]        row_number;
    logic signed [ACC_W-1:0] activity;
    logic                    violated;
    logic                    bad_sense;
    logic                    bad_index;
    logic                    any_violated;
  } row_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  cfg_idx_t             cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  scc_in_if  in_if ();
  scc_out_if out_if ();

  sparse_constraint_checker_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_if     (in_if),
    .out_if    (out_if)
  );

  // Shadow state of the checker.
  logic signed [VAL_W-1:0] var_shadow [VAR_DEPTH];
  bit                      var_loaded [VAR_DEPTH];
  int                      loaded_idx [$];
  logic signed [ACC_W-1:0] acc_shadow;
  logic [ROW_W-1:0]        row_shadow;
  logic                    idx_err_shadow;
  logic                    sticky_shadow;
  logic [NVAR_W-1:0]       num_vars_shadow;
  logic [SLACK_W-1:0]      abs_slack_shadow;

  row_result_t expected_rows [$];

  int errors = 0;
  int items_accepted = 0;
  int rows_checked = 0;
  int rows_violated = 0;
  int rows_bad_sense = 0;
  int rows_bad_index = 0;
  int rows_saturated = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $time);
    errors++;
  endtask

  function automatic logic signed [ACC_W-1:0] sat_accumulate(logic signed [ACC_W-1:0] a,
                                                             logic signed [ACC_W-1:0] b);
    logic signed [ACC_W-1:0] sum;
    sum = a + b;
    if (!a[ACC_W-1] && !b[ACC_W-1] && sum[ACC_W-1]) return ACC_MAX;
    if (a[ACC_W-1] && b[ACC_W-1] && !sum[ACC_W-1]) return ACC_MIN;
    return sum;
  endfunction

  // Advance the shadow state by one accepted item; queue the row result on a row end.
  task automatic absorb_item(action_t act, logic [IDX_W-1:0] idx, logic signed [VAL_W-1:0] val,
                             sense_t sense, logic signed [VAL_W-1:0] rhs);
    longint      rhs_q;
    longint      mag;
    longint      slack;
    longint      lim_hi;
    longint      lim_lo;
    row_result_t res;
    case (act)
      ACT_LOAD: begin
        var_shadow[idx] = val;
        if (!var_loaded[idx]) begin
          var_loaded[idx] = 1'b1;
          loaded_idx.push_back(idx);
        end
      end
      ACT_TERM: begin
        if (idx >= num_vars_shadow) begin
          idx_err_shadow = 1'b1;
        end else begin
          acc_shadow = sat_accumulate(acc_shadow, longint'(val) * longint'(var_shadow[idx]));
        end
      end
      ACT_END: begin
        rhs_q  = longint'(rhs);
        mag    = (rhs_q < 0) ? -rhs_q : rhs_q;
        slack  = ((mag * longint'(REL_MUL)) >>> REL_SHIFT) + longint'(abs_slack_shadow);
        lim_hi = (rhs_q + slack) <<< FRAC_BITS;
        lim_lo = (rhs_q - slack) <<< FRAC_BITS;
        res.violated  = 1'b0;
        res.bad_sense = 1'b0;
        case (sense)
          SENSE_LE: res.violated = acc_shadow > lim_hi;
          SENSE_GE: res.violated = acc_shadow < lim_lo;
          SENSE_EQ: res.violated = (acc_shadow > lim_hi) || (acc_shadow < lim_lo);
          default:  res.bad_sense = 1'b1;
        endcase
        res.bad_index = idx_err_shadow;
        if (res.violated || res.bad_sense || res.bad_index) sticky_shadow = 1'b1;
        res.any_violated = sticky_shadow;
        res.row_number   = row_shadow;
        res.activity     = acc_shadow;
        expected_rows.push_back(res);
        acc_shadow     = '0;
        idx_err_shadow = 1'b0;
        row_shadow     = row_shadow + ROW_W'(1);
      end
      default: ;
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(action_t act, logic [IDX_W-1:0] idx, logic signed [VAL_W-1:0] val,
                           sense_t sense, logic signed [VAL_W-1:0] rhs);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.action <= act;
    in_if.index  <= idx;
    in_if.value  <= val;
    in_if.sense  <= sense;
    in_if.rhs    <= rhs;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    absorb_item(act, idx, val, sense, rhs);
    items_accepted++;
    @(negedge clk);
  endtask

  // Registers change only with nothing in flight; leave room for terms still in the pipe.
  task automatic write_reg(cfg_idx_t which, logic [CFG_W-1:0] data);
    in_if.valid <= 1'b0;
    while (expected_rows.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (which)
      CFG_NUM_VARS:  num_vars_shadow  = data[NVAR_W-1:0];
      CFG_ABS_SLACK: abs_slack_shadow = data[SLACK_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [VAL_W-1:0] rand_q16();
    case ($urandom_range(0, 9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3, 4, 5, 6: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      default: return $urandom();
    endcase
  endfunction

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    row_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_rows.size() == 0) begin
        report_mismatch("unexpected row result", '0, out_if.row_number);
      end else begin
        want = expected_rows.pop_front();
        if (out_if.row_number !== want.row_number)
          report_mismatch("row_number", want.row_number, out_if.row_number);
        if (out_if.activity !== want.activity)
          report_mismatch("activity", want.activity, out_if.activity);
        if (out_if.violated !== want.violated)
          report_mismatch("violated", want.violated, out_if.violated);
        if (out_if.bad_sense !== want.bad_sense)
          report_mismatch("bad_sense", want.bad_sense, out_if.bad_sense);
        if (out_if.bad_index !== want.bad_index)
          report_mismatch("bad_index", want.bad_index, out_if.bad_index);
        if (out_if.any_violated !== want.any_violated)
          report_mismatch("any_violated", want.any_violated, out_if.any_violated);
        rows_checked++;
        rows_violated  += want.violated;
        rows_bad_sense += want.bad_sense;
        rows_bad_index += want.bad_index;
        if (want.activity == ACC_MAX || want.activity == ACC_MIN) rows_saturated++;
      end
    end
  end

  task automatic test_senses();
    send_item(ACT_LOAD, IDX_W'(0), VAL_MIN, SENSE_LE, '0);
    send_item(ACT_LOAD, IDX_W'(VAR_DEPTH - 1), VAL_MAX, SENSE_LE, '0);
    send_item(ACT_LOAD, IDX_W'(1), Q_ONE, SENSE_LE, '0);
    send_item(ACT_LOAD, IDX_W'(2), -Q_ONE, SENSE_LE, '0);
    // 2.0 against at most 1.0, -3.0 against at least -2.0, 5.0 equal to 5.0
    send_item(ACT_TERM, IDX_W'(1), 2 * Q_ONE, SENSE_LE, '0);
    send_item(ACT_END, IDX_W'(0), '0, SENSE_LE, Q_ONE);
    send_item(ACT_TERM, IDX_W'(2), 3 * Q_ONE, SENSE_LE, '0);
    send_item(ACT_END, IDX_W'(0), '0, SENSE_GE, -2 * Q_ONE);
    send_item(ACT_TERM, IDX_W'(1), 5 * Q_ONE, SENSE_LE, '0);
    send_item(ACT_END, IDX_W'(0), '0, SENSE_EQ, 5 * Q_ONE);
    send_item(ACT_END, IDX_W'(VAR_DEPTH - 1), VAL_MAX, SENSE_BAD, VAL_MIN);
  endtask

  task automatic test_saturation();
    // Two products of 2^62 overflow upward; three near -2^62 overflow downward.
    send_item(ACT_TERM, IDX_W'(0), VAL_MIN, SENSE_LE, '0);
    send_item(ACT_TERM, IDX_W'(0), VAL_MIN, SENSE_LE, '0);
    send_item(ACT_END, IDX_W'(0), '0, SENSE_LE, VAL_MAX);
    repeat (3) send_item(ACT_TERM, IDX_W'(0), VAL_MAX, SENSE_LE, '0);
    send_item(ACT_END, IDX_W'(0), '0, SENSE_GE, '0);
  endtask

  task automatic test_ignored_action();
    send_item(ACT_TERM, IDX_W'(1), Q_ONE, SENSE_LE, '0);
    send_item(ACT_NONE, IDX_W'($urandom_range(0, VAR_DEPTH - 1)), $urandom(),
              sense_t'($urandom_range(0, 3)), $urandom());
    send_item(ACT_END, IDX_W'(0), '0, SENSE_EQ, Q_ONE);
  endtask

  task automatic test_bad_index();
    write_reg(CFG_NUM_VARS, CFG_W'(2));
    write_reg(CFG_ABS_SLACK, CFG_W'(0));
    // Out of range for terms, but a load still lands in the store.
    send_item(ACT_LOAD, IDX_W'(3), 2 * Q_ONE, SENSE_LE, '0);
    send_item(ACT_TERM, IDX_W'(VAR_DEPTH - 1), Q_ONE, SENSE_LE, '0);
    send_item(ACT_TERM, IDX_W'(1), Q_ONE, SENSE_LE, '0);
    send_item(ACT_END, IDX_W'(0), '0, SENSE_LE, VAL_MAX);
    write_reg(CFG_NUM_VARS, CFG_W'(VAR_DEPTH));
    send_item(ACT_TERM, IDX_W'(3), Q_ONE, SENSE_LE, '0);
    send_item(ACT_END, IDX_W'(0), '0, SENSE_EQ, 2 * Q_ONE);
  endtask

  // One row with random content, loads mixed in ahead and ignored items as noise.
  task automatic send_random_row(inout int count);
    int                      n_terms;
    longint                  base;
    longint                  margin;
    longint                  near;
    logic signed [VAL_W-1:0] rhs_pick;
    if ($urandom_range(0, 99) < 40) begin
      repeat ($urandom_range(1, 3)) begin
        send_item(ACT_LOAD, IDX_W'($urandom_range(0, VAR_DEPTH - 1)), rand_q16(),
                  sense_t'($urandom_range(0, 3)), $urandom());
        count++;
      end
    end
    n_terms = $urandom_range(0, 6);
    repeat (n_terms) begin
      if ($urandom_range(0, 99) < 8)
        send_item(ACT_NONE, IDX_W'($urandom_range(0, VAR_DEPTH - 1)), $urandom(),
                  sense_t'($urandom_range(0, 3)), $urandom());
      send_item(ACT_TERM, IDX_W'(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)]),
                rand_q16(), sense_t'($urandom_range(0, 3)), $urandom());
      count++;
    end
    // Aim half the right-hand sides at the edges or the centre of the slack band.
    base   = acc_shadow >>> FRAC_BITS;
    margin = (((base < 0) ? -base : base) * longint'(REL_MUL)) >>> REL_SHIFT;
    margin = margin + longint'(abs_slack_shadow);
    case ($urandom_range(0, 2))
      0: near = base + margin;
      1: near = base - margin;
      default: near = base;
    endcase
    near = near + longint'($urandom_range(0, 4)) - 2;
    if (near > 64'sh7fff_ffff) near = 64'sh7fff_ffff;
    if (near < -64'sh8000_0000) near = -64'sh8000_0000;
    rhs_pick = ($urandom_range(0, 1) != 0) ? near[VAL_W-1:0] : rand_q16();
    send_item(ACT_END, IDX_W'($urandom_range(0, VAR_DEPTH - 1)), $urandom(),
              sense_t'($urandom_range(0, 3)), rhs_pick);
    count++;
  endtask

  task automatic test_random_phases();
    int count;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_NUM_VARS, CFG_W'(VAR_DEPTH));
          write_reg(CFG_ABS_SLACK, CFG_W'(0));
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          write_reg(CFG_NUM_VARS, CFG_W'($urandom_range(1, VAR_DEPTH - 1)));
          write_reg(CFG_ABS_SLACK, CFG_W'($urandom_range(0, 32'h7fff_ffff)));
          send_idle_pct = 77;
          stall_pct     = 0;
        end
        2: begin
          write_reg(CFG_NUM_VARS, CFG_W'(0));
          write_reg(CFG_ABS_SLACK, 31'h7fff_ffff);
          send_idle_pct = 0;
          stall_pct     = 77;
        end
        default: begin
          write_reg(CFG_NUM_VARS, CFG_W'($urandom_range(0, VAR_DEPTH)));
          write_reg(CFG_ABS_SLACK, CFG_W'(ABS_SLACK_RST));
          send_idle_pct = 14;
          stall_pct     = 14;
        end
      endcase
      count = 0;
      while (count < ITEMS_PER_PHASE) send_random_row(count);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_NUM_VARS;
    cfg_data     = '0;
    in_if.valid  = 1'b0;
    in_if.action = ACT_LOAD;
    in_if.index  = '0;
    in_if.value  = '0;
    in_if.sense  = SENSE_LE;
    in_if.rhs    = '0;
    out_if.ready = 1'b0;
    acc_shadow       = '0;
    row_shadow       = '0;
    idx_err_shadow   = 1'b0;
    sticky_shadow    = 1'b0;
    num_vars_shadow  = NUM_VARS_RST;
    abs_slack_shadow = ABS_SLACK_RST;
    // hold reset, then release it at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_senses();
    test_saturation();
    test_ignored_action();
    test_bad_index();
    test_random_phases();

    in_if.valid <= 1'b0;
    while (expected_rows.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Checked %0d row results from %0d accepted items over four handshake phases",
             rows_checked, items_accepted);
    $display("Rows flagged: %0d violated, %0d bad sense, %0d bad index, %0d saturated",
             rows_violated, rows_bad_sense, rows_bad_index, rows_saturated);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
design/scc_pkg.sv
design/scc_in_if.sv
design/scc_out_if.sv
design/scc_ram.sv
design/sparse_constraint_checker_unit.sv
dv/tb_sparse_constraint_checker_unit.sv
